FILE: src/swqc_pkg.sv
// ----------------------------------------------------------------------------
// swqc_pkg
// Shared widths and register indexes of the sliding-window quota counter.
// ----------------------------------------------------------------------------
package swqc_pkg;

  localparam int KIND_W  = 3;   // symbol kind code
  localparam int LEN_W   = 9;   // window length, quotas, fill level
  localparam int TALLY_W = 9;   // per-kind tallies
  localparam int OTOT_W  = 16;  // qualifying_total field
  localparam int CIDX_W  = 3;   // configuration index

  localparam logic [CIDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FIRST_KIND    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SECOND_KIND   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_FIRST_NEEDED  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SECOND_NEEDED = 3'd4;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

endpackage

FILE: src/sliding_window_two_kind_quota_count.sv
// ----------------------------------------------------------------------------
// sliding_window_two_kind_quota_count
// Windowed tally of two symbol kinds with per-window quota check.
// ----------------------------------------------------------------------------
// The block takes one symbol beat per clock while the output side is not
// stalled and returns one result beat per symbol, registered in stage 1 and
// again in the output register. The symbol ring lives in a RAM with one
// write and one registered read port, so each beat writes its own symbol and
// reads the symbol leaving the window in the same cycle, and the tallies are
// updated from that read data in stage 2. The window length is
// clamped to 1..WINDOW_MAX. After a beat with tlast, all sequence state
// (slot, fill level, tallies and the qualifying count) returns to zero; the
// configuration registers are kept. Ring entries from earlier sequences are
// never read before being rewritten, so no clearing pass is needed. Write
// configuration only while no beats are in flight.
// ----------------------------------------------------------------------------
module sliding_window_two_kind_quota_count
  import swqc_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int TOTAL_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // symbol input
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [2:0] symbol_kind
  input  logic                in_tlast,   // sequence_end
  // result output
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,  // [15:0] qualifying_total
  output logic [1:0]          out_tuser,  // [0] window_full, [1] window_qualifies
  output logic                out_tlast,  // sequence_done
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [LEN_W-1:0]    cfg_data
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);
  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW_MAX - 1);
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  // configuration registers
  logic [LEN_W-1:0]  win_len_r;
  logic [KIND_W-1:0] first_kind_r;
  logic [KIND_W-1:0] second_kind_r;
  logic [LEN_W-1:0]  first_need_r;
  logic [LEN_W-1:0]  second_need_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r     <= LEN_W'(1);
      first_kind_r  <= KIND_W'(0);
      second_kind_r <= KIND_W'(1);
      first_need_r  <= '0;
      second_need_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: win_len_r     <= cfg_data;
        REG_FIRST_KIND:    first_kind_r  <= cfg_data[KIND_W-1:0];
        REG_SECOND_KIND:   second_kind_r <= cfg_data[KIND_W-1:0];
        REG_FIRST_NEEDED:  first_need_r  <= cfg_data;
        REG_SECOND_NEEDED: second_need_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective window length: zero reads as one, clamp to the ring depth
  logic [CW-1:0]    wl_ext;
  logic [CW-1:0]    len_ext;
  logic [LEN_W-1:0] len_eff;

  always_comb begin
    wl_ext = CW'(win_len_r);
    if (win_len_r == '0) begin
      len_ext = CW'(1);
    end else if (wl_ext > WMAX_C) begin
      len_ext = WMAX_C;
    end else begin
      len_ext = wl_ext;
    end
    len_eff = len_ext[LEN_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accept, write the symbol, read the one leaving the window
  // ---------------------------------------------------------------------------
  logic [AW-1:0]     slot_r, slot_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              s1_valid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_remove_r;
  logic              s1_full_r;
  logic              s1_last_r;

  logic              advance;
  logic              in_fire;
  logic [KIND_W-1:0] in_kind;
  logic              remove;
  logic              full;
  logic [CW-1:0]     slot_ext;
  logic [CW-1:0]     old_ext;
  logic [LEN_W:0]    fill_inc;
  logic [KIND_W-1:0] old_kind;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign in_kind   = in_tdata[KIND_W-1:0];

  always_comb begin
    slot_ext = CW'(slot_r);
    if (slot_ext >= len_ext) begin
      old_ext = slot_ext - len_ext;
    end else begin
      old_ext = slot_ext + WMAX_C - len_ext;
    end
    remove   = fill_r >= len_eff;
    fill_inc = {1'b0, fill_r} + 1'b1;
    full     = remove || (fill_inc >= {1'b0, len_eff});
    fill_nxt = remove ? len_eff : fill_inc[LEN_W-1:0];
    slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  end

  swqc_ram #(
    .WIDTH (KIND_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (in_fire),
    .waddr (slot_r),
    .wdata (in_kind),
    .re    (in_fire),
    .raddr (old_ext[AW-1:0]),
    .rdata (old_kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      fill_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        // a sequence end restarts the window for the next beat
        slot_r <= in_tlast ? '0 : slot_nxt;
        fill_r <= in_tlast ? '0 : fill_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= in_kind;
      s1_remove_r <= remove;
      s1_full_r   <= full;
      s1_last_r   <= in_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: update tallies from the leaving symbol, check quotas
  // ---------------------------------------------------------------------------
  logic [TALLY_W-1:0]     first_tally_r, first_tally_nxt;
  logic [TALLY_W-1:0]     second_tally_r, second_tally_nxt;
  logic [TOTAL_WIDTH-1:0] total_r, total_nxt;
  logic                   qualifies;
  logic [TALLY_W-1:0]     first_mid;
  logic [TALLY_W-1:0]     second_mid;
  logic                   s2_fire;

  assign s2_fire = s1_valid_r && advance;

  always_comb begin
    first_mid  = first_tally_r;
    second_mid = second_tally_r;
    // drop the symbol leaving the window, saturating at zero
    if (s1_remove_r) begin
      if (old_kind == first_kind_r) begin
        if (first_mid != '0) first_mid = first_mid - 1'b1;
      end else if (old_kind == second_kind_r) begin
        if (second_mid != '0) second_mid = second_mid - 1'b1;
      end
    end
    first_tally_nxt  = first_mid;
    second_tally_nxt = second_mid;
    // add the new symbol, saturating at the tally maximum
    if (s1_kind_r == first_kind_r) begin
      if (first_mid != TALLY_MAX) first_tally_nxt = first_mid + 1'b1;
    end else if (s1_kind_r == second_kind_r) begin
      if (second_mid != TALLY_MAX) second_tally_nxt = second_mid + 1'b1;
    end
    qualifies = s1_full_r && (first_tally_nxt >= first_need_r) &&
                (second_tally_nxt >= second_need_r);
    total_nxt = (qualifies && total_r != TOTAL_MAX) ? total_r + 1'b1 : total_r;
  end

  logic                   out_valid_r;
  logic [TOTAL_WIDTH-1:0] out_total_r;
  logic                   out_full_r;
  logic                   out_qual_r;
  logic                   out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_tally_r  <= '0;
      second_tally_r <= '0;
      total_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s2_fire) begin
        first_tally_r  <= s1_last_r ? '0 : first_tally_nxt;
        second_tally_r <= s1_last_r ? '0 : second_tally_nxt;
        total_r        <= s1_last_r ? '0 : total_nxt;
      end
      if (s2_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_total_r <= total_nxt;
      out_full_r  <= s1_full_r;
      out_qual_r  <= qualifies;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OTOT_W'(out_total_r);
  assign out_tuser  = {out_qual_r, out_full_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: src/swqc_ram.sv
// ----------------------------------------------------------------------------
// swqc_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module swqc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/sliding_window_two_kind_quota_count_test.sv
// ----------------------------------------------------------------------------
// sliding_window_two_kind_quota_count_test
// Self-checking bench for the windowed two-kind quota counter.
// ----------------------------------------------------------------------------
// Symbol beats go in through the input stream and every result beat is
// checked, field by field, against a running model of the window kept here.
// Directed sequences cover the reset settings, odd register values and a
// window length change in the middle of a sequence. Random sequences with
// random settings follow, then one long sequence with the largest window,
// then a stretch with both sides streaming at full rate.
// ----------------------------------------------------------------------------
module sliding_window_two_kind_quota_count_test;
  import swqc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 256;

  // One result beat as the block reports it.
  typedef struct packed {
    logic              full;
    logic              qual;
    logic [OTOT_W-1:0] total;
    logic              done;
  } window_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // [2:0] symbol_kind
  logic                in_tlast = 1'b0; // sequence_end
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;       // [15:0] qualifying_total
  logic [1:0]          out_tuser;       // [0] window_full, [1] window_qualifies
  logic                out_tlast;       // sequence_done
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [LEN_W-1:0]    cfg_data = '0;

  // Register copies, at their reset values.
  logic [LEN_W-1:0]    set_length = 9'd1;
  logic [KIND_W-1:0]   set_first_kind = 3'd0;
  logic [KIND_W-1:0]   set_second_kind = 3'd1;
  logic [LEN_W-1:0]    set_first_need = '0;
  logic [LEN_W-1:0]    set_second_need = '0;

  // Window state as the block should hold it.
  logic [KIND_W-1:0]   recent_kinds [RING_DEPTH];
  logic [7:0]          ring_slot = '0;
  int unsigned         window_fill = 0;
  logic [TALLY_W-1:0]  first_count = '0;
  logic [TALLY_W-1:0]  second_count = '0;
  logic [OTOT_W-1:0]   qualified_windows = '0;

  window_report_t      expected_reports [$];
  bit                  steady = 1'b0;   // no idling on either side
  bit                  failed = 1'b0;

  sliding_window_two_kind_quota_count dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("sliding_window_two_kind_quota_count_test failed");
    $finish;
  end

  // Stall the result side in about 28 percent of cycles.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 28);
  end

  // Advance the window by one symbol and return the report it should cause.
  function automatic window_report_t slide_window(logic [KIND_W-1:0] kind, logic last);
    int unsigned    span;
    logic [KIND_W-1:0] leaving;
    window_report_t rep;
    // Zero length acts as one, oversize lengths clamp to the ring depth.
    span = (set_length == 0) ? 1 : ((set_length > RING_DEPTH) ? RING_DEPTH : set_length);
    if (window_fill >= span) begin
      // The symbol leaving is the one written span beats ago; wraps mod 256.
      leaving = recent_kinds[ring_slot - 8'(span)];
      if (leaving == set_first_kind) begin
        if (first_count != 0) first_count--;
      end else if (leaving == set_second_kind) begin
        if (second_count != 0) second_count--;
      end
      window_fill = span;
    end else begin
      window_fill++;
    end
    recent_kinds[ring_slot] = kind;
    ring_slot++;
    // A symbol matching both kinds only counts toward the first.
    if (kind == set_first_kind) begin
      if (first_count != TALLY_MAX) first_count++;
    end else if (kind == set_second_kind) begin
      if (second_count != TALLY_MAX) second_count++;
    end
    rep.full  = (window_fill >= span);
    rep.qual  = rep.full && (first_count >= set_first_need) &&
                (second_count >= set_second_need);
    if (rep.qual && qualified_windows != '1) qualified_windows++;
    rep.total = qualified_windows;
    rep.done  = last;
    if (last) begin
      // Sequence state clears, registers stay.
      foreach (recent_kinds[i]) recent_kinds[i] = '0;
      ring_slot = '0;
      window_fill = 0;
      first_count = '0;
      second_count = '0;
      qualified_windows = '0;
    end
    return rep;
  endfunction

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    window_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with no expectation pending");
        failed = 1'b1;
      end else begin
        want = expected_reports.pop_front();
        if (out_tuser[0] !== want.full) begin
          $error("window_full: expected %0d, got %0d", want.full, out_tuser[0]);
          failed = 1'b1;
        end
        if (out_tuser[1] !== want.qual) begin
          $error("window_qualifies: expected %0d, got %0d", want.qual, out_tuser[1]);
          failed = 1'b1;
        end
        if (out_tdata !== want.total) begin
          $error("qualifying_total: expected %0d, got %0d", want.total, out_tdata);
          failed = 1'b1;
        end
        if (out_tlast !== want.done) begin
          $error("sequence_done: expected %0d, got %0d", want.done, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  // Send one symbol beat, with a random gap ahead of it unless streaming.
  task automatic send_symbol(logic [KIND_W-1:0] kind, logic last);
    if (!steady) begin
      while ($urandom_range(99) < 28) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 8'(kind);
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    expected_reports.push_back(slide_window(kind, last));
  endtask

  // Hold the input until every pending result is back, then settle.
  task automatic wait_drained(int settle);
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Drain, then write all five registers back to back.
  task automatic apply_settings(logic [LEN_W-1:0] len, logic [KIND_W-1:0] ka,
                                logic [KIND_W-1:0] kb, logic [LEN_W-1:0] na,
                                logic [LEN_W-1:0] nb);
    logic [LEN_W-1:0] vals [5];
    vals[REG_WINDOW_LENGTH] = len;
    vals[REG_FIRST_KIND]    = LEN_W'(ka);
    vals[REG_SECOND_KIND]   = LEN_W'(kb);
    vals[REG_FIRST_NEEDED]  = na;
    vals[REG_SECOND_NEEDED] = nb;
    wait_drained(4);
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CIDX_W'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    set_length      = len;
    set_first_kind  = ka;
    set_second_kind = kb;
    set_first_need  = na;
    set_second_need = nb;
  endtask

  // Reset settings: window of one, every beat qualifies.
  task automatic test_reset_defaults();
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd7, 1'b0);
    send_symbol(3'd4, 1'b1);
  endtask

  task automatic test_odd_settings();
    // Zero length acts as one; kinds above 4 count like any other code.
    apply_settings(9'd0, 3'd7, 3'd5, 9'd1, 9'd1);
    send_symbol(3'd7, 1'b0);
    send_symbol(3'd5, 1'b0);
    send_symbol(3'd6, 1'b1);
    // Both counters on the same kind: only the first one grows.
    apply_settings(9'd3, 3'd2, 3'd2, 9'd2, 9'd0);
    send_symbol(3'd2, 1'b0);
    send_symbol(3'd2, 1'b0);
    send_symbol(3'd3, 1'b0);
    send_symbol(3'd2, 1'b1);
    // Oversize window and a sequence far shorter than it: total stays zero.
    apply_settings(9'd511, 3'd4, 3'd3, 9'd0, 9'd0);
    send_symbol(3'd4, 1'b0);
    send_symbol(3'd3, 1'b0);
    send_symbol(3'd0, 1'b1);
    // Quotas beyond any window: full windows that never qualify.
    apply_settings(9'd4, 3'd0, 3'd1, 9'd511, 9'd256);
    repeat (3) send_symbol(3'd0, 1'b0);
    send_symbol(3'd0, 1'b1);
  endtask

  // Shrink then grow the window inside one sequence.
  task automatic test_window_change();
    apply_settings(9'd4, 3'd0, 3'd1, 9'd2, 9'd1);
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    apply_settings(9'd2, 3'd0, 3'd1, 9'd1, 9'd1);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd0, 1'b0);
    apply_settings(9'd6, 3'd0, 3'd1, 9'd2, 9'd1);
    send_symbol(3'd0, 1'b0);
    send_symbol(3'd1, 1'b0);
    send_symbol(3'd0, 1'b1);
  endtask

  // Random settings, then a sequence of symbols biased toward both kinds.
  task automatic test_random_sequences(int item_budget);
    int sent;
    int len;
    int seq_len;
    int pick;
    logic [KIND_W-1:0] ka;
    logic [KIND_W-1:0] kb;
    logic [LEN_W-1:0]  na;
    logic [LEN_W-1:0]  nb;
    logic [KIND_W-1:0] kind;
    sent = 0;
    while (sent < item_budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 10);
      ka  = 3'($urandom_range(7));
      kb  = ($urandom_range(4) == 0) ? ka : 3'($urandom_range(7));
      na  = ($urandom_range(19) == 0) ? 9'd511 : 9'($urandom_range(0, (len * 2) / 3 + 1));
      nb  = 9'($urandom_range(0, len / 2 + 1));
      apply_settings(9'(len), ka, kb, na, nb);
      seq_len = $urandom_range(1, 3 * len + 4);
      for (int i = 0; i < seq_len; i++) begin
        // Now and then hold off until the block has caught up.
        if (i > 0 && $urandom_range(29) == 0) wait_drained(3);
        // Occasionally move the window length mid-sequence.
        if (i > 0 && $urandom_range(49) == 0) begin
          len = $urandom_range(1, 12);
          apply_settings(9'(len), ka, kb, na, nb);
        end
        pick = $urandom_range(9);
        if (pick < 4) kind = ka;
        else if (pick < 7) kind = kb;
        else kind = 3'($urandom_range(7));
        send_symbol(kind, i == seq_len - 1);
      end
      sent += seq_len;
    end
  endtask

  // One long sequence on the largest window, so it actually fills.
  task automatic test_long_window();
    logic [KIND_W-1:0] ka;
    logic [KIND_W-1:0] kb;
    int n;
    ka = 3'($urandom_range(7));
    kb = 3'($urandom_range(7));
    apply_settings($urandom_range(1) ? 9'd256 : 9'($urandom_range(257, 511)), ka, kb,
                   9'($urandom_range(0, 120)), 9'($urandom_range(0, 60)));
    n = $urandom_range(262, 280);
    for (int i = 0; i < n; i++) begin
      send_symbol(($urandom_range(2) == 0) ? ka : 3'($urandom_range(7)), i == n - 1);
    end
  endtask

  // Full-rate stretch: no gaps and no stalls.
  task automatic test_steady_stream();
    steady = 1'b1;
    test_random_sequences(150);
    steady = 1'b0;
  endtask

  initial begin
    foreach (recent_kinds[i]) recent_kinds[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_odd_settings();
    test_window_change();
    test_random_sequences(700);
    test_long_window();
    test_steady_stream();
    wait_drained(8);
    if (!failed) begin
      $display("sliding_window_two_kind_quota_count_test passed");
    end else begin
      $display("sliding_window_two_kind_quota_count_test failed");
    end
    $finish;
  end

endmodule
